### rtl/gse_pkg.sv
// shared types and constants for the gray sobel edge stream unit
`default_nettype none

package gse_pkg;

  // one gray or colour sample
  typedef logic [7:0] pix_t;

  // 3x3 window, index row*3 + col, row 0 on top, col 2 newest
  typedef logic [8:0][7:0] win_t;

  // gray weights in units of 1/256
  localparam logic [15:0] GRAY_B = 16'd18;
  localparam logic [15:0] GRAY_G = 16'd183;
  localparam logic [15:0] GRAY_R = 16'd54;

  // largest magnitude that fits the result
  localparam logic [10:0] MAG_MAX = 11'd255;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // per-beat control carried from the address stage to the window stage
  typedef struct packed {
    logic wr_en;      // line stores take the beat (not a flush beat)
    logic emit;       // beat produces a result
    logic sobel_sel;  // interior position, use the kernel
    logic last;       // last result of the frame
  } s1_ctrl_t;

endpackage

`default_nettype wire

### rtl/gse_sobel.sv
// sobel kernel on a 3x3 gray window with saturated magnitude
`default_nettype none

module gse_sobel
  import gse_pkg::*;
(
  input  win_t win,
  output pix_t mag
);

  logic [9:0]         gx_pos;
  logic [9:0]         gx_neg;
  logic [9:0]         gy_pos;
  logic [9:0]         gy_neg;
  logic [9:0]         gx_abs;
  logic [9:0]         gy_abs;
  logic [10:0]        sum;

  // weighted column and row sums
  assign gx_pos = {2'b0, win[2]} + {1'b0, win[5], 1'b0} + {2'b0, win[8]};
  assign gx_neg = {2'b0, win[0]} + {1'b0, win[3], 1'b0} + {2'b0, win[6]};
  assign gy_pos = {2'b0, win[0]} + {1'b0, win[1], 1'b0} + {2'b0, win[2]};
  assign gy_neg = {2'b0, win[6]} + {1'b0, win[7], 1'b0} + {2'b0, win[8]};

  // absolute differences
  assign gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
  assign gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);

  // magnitude with saturation
  assign sum = {1'b0, gx_abs} + {1'b0, gy_abs};
  assign mag = (sum > MAG_MAX) ? MAG_MAX[7:0] : sum[7:0];

endmodule

`default_nettype wire

### rtl/gray_sobel_edge_stream_unit.sv
// a beat passes the window stage registers, then the output register, before out_valid
// throughput: one beat per cycle if not stalled, set by one read port per line store
// results trail the pixels by image_width+1 positions; drain beats flush the tail
// reset (rst_n low, synchronous): positions, window and valids cleared, sizes 640x480
// line stores are not cleared; early beats read entries not yet written
`default_nettype none

module gray_sobel_edge_stream_unit
  import gse_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire         clk,
  input  wire         rst_n,
  // pixel input
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_op,
  input  wire  [7:0]  in_blue,
  input  wire  [7:0]  in_green,
  input  wire  [7:0]  in_red,
  // result output
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_edge_res,
  output logic        out_frame_end,
  // register port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;

  // registers
  logic [11:0]    width_r;
  logic [11:0]    height_r;
  logic           cfg_wr;

  // positions
  logic [12:0]    in_row_r, in_row_nxt;
  logic [CW-1:0]  in_col_r, in_col_nxt;
  logic [11:0]    out_row_r, out_row_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;

  logic [WW-1:0]  w_eff;
  logic [11:0]    h_eff;
  logic [11:0]    h_m1;
  logic [WW-1:0]  w_m1;

  // address stage
  logic           acc;
  logic           take;
  logic           flushing;
  s1_ctrl_t       ctrl0;
  pix_t           gray0;
  logic [15:0]    prod_b;
  logic [15:0]    prod_g;
  logic [15:0]    prod_r;
  logic           in_wrap;
  logic           out_wrap;

  // window stage
  logic           s1_valid_r;
  s1_ctrl_t       s1_ctrl_r;
  pix_t           s1_gray_r;
  logic [CW-1:0]  s1_addr_r;
  logic           s1_adv;
  pix_t           above_rd_r;
  pix_t           cur_rd_r;
  win_t           win_r, win_nxt;
  pix_t           sobel_mag;

  // output register
  logic           out_valid_r;
  pix_t           out_edge_r;
  logic           out_last_r;

  // line stores
  pix_t           above_mem [MAX_WIDTH];
  pix_t           cur_mem   [MAX_WIDTH];

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {20'b0, height_r} : {20'b0, width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 12'd480;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_r <= pwdata[11:0];
      end else begin
        height_r <= pwdata[11:0];
      end
    end
  end

  // clamped frame size
  always_comb begin
    if (WW'(width_r) < WW'(3)) begin
      w_eff = WW'(3);
    end else if (WW'(width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    h_eff = (height_r < 12'd3) ? 12'd3 : height_r;
    h_m1  = h_eff - 12'd1;
    w_m1  = w_eff - WW'(1);
  end

  // handshake: stall only when both downstream slots are held
  assign s1_adv   = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;
  assign acc      = in_valid & in_ready;

  // beat classification from the positions, with in_op for take
  always_comb begin
    flushing        = in_row_r >= {1'b0, h_eff};
    take            = acc & ~(in_op & ~flushing);
    ctrl0.wr_en     = ~flushing;
    ctrl0.emit      = (in_row_r >= 13'd2) || ((in_row_r == 13'd1) && (in_col_r != '0));
    ctrl0.sobel_sel = !((in_col_r == '0) || (out_row_r == 12'd0) || (out_row_r >= h_m1) ||
                        (out_col_r == '0) || (WW'(out_col_r) >= w_m1));
    ctrl0.last      = (out_row_r == h_m1) && (WW'(out_col_r) == w_m1);
  end

  // gray conversion
  always_comb begin
    prod_b = {8'b0, in_blue}  * GRAY_B;
    prod_g = {8'b0, in_green} * GRAY_G;
    prod_r = {8'b0, in_red}   * GRAY_R;
    gray0  = flushing ? '0 : (prod_b[15:8] + prod_g[15:8] + prod_r[15:8]);
  end

  // position update
  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    in_wrap     = (WW'(in_col_r) + WW'(1)) >= w_eff;
    out_wrap    = (WW'(out_col_r) + WW'(1)) >= w_eff;
    if (cfg_wr) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (take) begin
      if (in_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 13'd1;
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (ctrl0.emit) begin
        if (out_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 12'd1;
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
        if (ctrl0.last) begin
          in_row_nxt  = '0;
          in_col_nxt  = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  // line store read at the beat's column; data held while the stage stalls
  always_ff @(posedge clk) begin
    if (take) begin
      above_rd_r <= above_mem[in_col_r];
      cur_rd_r   <= cur_mem[in_col_r];
    end
  end

  // write back: the current row moves up, the new gray enters.
  // the same column is read again only w_eff beats later, after this write
  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctrl_r.wr_en) begin
      above_mem[s1_addr_r] <= cur_rd_r;
      cur_mem[s1_addr_r]   <= s1_gray_r;
    end
  end

  // window stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctrl_r <= ctrl0;
      s1_gray_r <= gray0;
      s1_addr_r <= in_col_r;
    end
  end

  // window shift with the new column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3]   = win_r[k*3+1];
      win_nxt[k*3+1] = win_r[k*3+2];
    end
    win_nxt[2] = above_rd_r;
    win_nxt[5] = cur_rd_r;
    win_nxt[8] = s1_gray_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  gse_sobel u_sobel (
    .win (win_nxt),
    .mag (sobel_mag)
  );

  // output register; borders take the centre, which is the old middle newest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_ctrl_r.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_edge_r <= s1_ctrl_r.sobel_sel ? sobel_mag : win_r[5];
      out_last_r <= s1_ctrl_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_edge_res  = out_edge_r;
  assign out_frame_end = out_last_r;

`ifndef SYNTH
  // a held window-stage beat is not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("window stage beat lost while stalled");

  // input stalls only when both slots are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without cause");

  // a write back never hits the column being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_ctrl_r.wr_en && take |-> s1_addr_r != in_col_r)
    else $error("line store read and write at the same column");

  // the last result of a frame restarts all positions
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && !cfg_wr && ctrl0.emit && ctrl0.last |=>
      in_row_r == 13'd0 && in_col_r == '0 && out_row_r == 12'd0 && out_col_r == '0)
    else $error("positions not restarted after frame end");
`endif

endmodule

`default_nettype wire
